@@ rtl/spcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_pkg
// Types and constants shared by the smoothed person crop window block.
// ----------------------------------------------------------------------------
package spcw_pkg;

  localparam int COORD_W     = 12;  // box and region corner coordinate
  localparam int BOX_EXT_W   = 13;  // box width and height as received
  localparam int EXT_W       = 14;  // union extent, right/bottom edge
  localparam int CLASS_W     = 8;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_LEN_W   = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int CROP_X_W    = 15;
  localparam int CROP_W_W    = 14;
  localparam int OUT_EXT_W   = 13;
  localparam int CX_W        = 17;  // signed working width of the crop x
  localparam int DIV_N_W     = 27;  // dividend: frame width times region height
  localparam int DIV_D_W     = 13;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  localparam logic [CROP_W_W-1:0]  CROP_W_MAX    = 14'd16383;
  localparam logic [CLASS_W-1:0]   PERSON_CLASS  = 8'd0;
  localparam logic [DIV_D_W-1:0]   THIRD_DIVISOR = 13'd3;

  localparam logic [CFG_DIM_W-1:0] FRAME_W_RST   = 13'd1920;
  localparam logic [CFG_DIM_W-1:0] FRAME_H_RST   = 13'd1080;
  localparam logic [CFG_LEN_W-1:0] WIN_LEN_RST   = 6'd30;
  localparam logic                 SMOOTH_RST    = 1'b1;
  localparam logic                 TOP_THIRD_RST = 1'b0;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_W   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_H   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_LEN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP_THIRD = 3'd4;

  // divider operations
  typedef logic [2:0] op_t;
  localparam op_t OP_AVG_X  = 3'd0;
  localparam op_t OP_AVG_Y  = 3'd1;
  localparam op_t OP_AVG_W  = 3'd2;
  localparam op_t OP_AVG_H  = 3'd3;
  localparam op_t OP_THIRD  = 3'd4;
  localparam op_t OP_ASPECT = 3'd5;

  typedef struct packed {
    logic [5:0]           spare;
    logic [CLASS_W-1:0]   class_id;
    logic [BOX_EXT_W-1:0] box_h;
    logic [BOX_EXT_W-1:0] box_w;
    logic [COORD_W-1:0]   box_y;
    logic [COORD_W-1:0]   box_x;
  } in_word_t;

  typedef struct packed {
    logic [OUT_EXT_W-1:0] region_h;
    logic [OUT_EXT_W-1:0] region_w;
    logic [COORD_W-1:0]   region_y;
    logic [COORD_W-1:0]   region_x;
    logic [OUT_EXT_W-1:0] crop_h;
    logic [CROP_W_W-1:0]  crop_w;
    logic [COORD_W-1:0]   crop_y;
    logic [CROP_X_W-1:0]  crop_x;
  } out_word_t;

  typedef struct packed {
    logic [EXT_W-1:0]   h;
    logic [EXT_W-1:0]   w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } win_entry_t;

  typedef struct packed {
    logic upd;
    logic load_cur;
    logic div_start;
    logic div_wr;
    op_t  op;
    logic mul;
    logic fin;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic smooth;
    logic top_third;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/spcw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spcw_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/spcw_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spcw_div
  import spcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic      [DIV_N_W-1:0] quot,
  output logic                    done
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0] num_r, num_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   rem_sub;
  logic               ge;

  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_N_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_N_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift the quotient bit in where the dividend bit leaves
      rem_nxt = ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      num_nxt = {num_r[DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign quot = num_r;
  assign done = done_r;

endmodule
`default_nettype wire

@@ rtl/spcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_ctrl
// Sequencer for the frame-end work: window update, divisions, aspect fit.
// ----------------------------------------------------------------------------
module spcw_ctrl
  import spcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_mode,
  output logic           in_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  op_t        op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_mode) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (stat.count_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.load_cur = 1'b1;
          if (stat.smooth) begin
            op_nxt    = OP_AVG_X;
            state_nxt = ST_DIV;
          end else if (stat.top_third) begin
            op_nxt    = OP_THIRD;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          case (op_r)
            OP_AVG_X: begin
              op_nxt    = OP_AVG_Y;
              state_nxt = ST_DIV;
            end
            OP_AVG_Y: begin
              op_nxt    = OP_AVG_W;
              state_nxt = ST_DIV;
            end
            OP_AVG_W: begin
              op_nxt    = OP_AVG_H;
              state_nxt = ST_DIV;
            end
            OP_AVG_H: begin
              if (stat.top_third) begin
                op_nxt    = OP_THIRD;
                state_nxt = ST_DIV;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            OP_THIRD: state_nxt = ST_MUL;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        op_nxt    = OP_ASPECT;
        state_nxt = ST_DIV;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_AVG_X;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/spcw_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_dp
// Datapath: configuration, box union, window store and sums, shared divider,
// aspect fit and output register.
// ----------------------------------------------------------------------------
module spcw_dp
  import spcw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_fire,
  input  wire logic                   in_mode,
  input  wire in_word_t               in_data,
  input  wire ctrl_cmd_t              cmd,
  output dp_stat_t                    stat,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser
);

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int LEN_W  = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
  localparam int SUMC_W = COORD_W + $clog2(WINDOW_DEPTH);
  localparam int SUME_W = EXT_W + $clog2(WINDOW_DEPTH);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [PTR_W:0]   PTR_WRAP = (PTR_W + 1)'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(WINDOW_DEPTH);

  // configuration
  logic [CFG_DIM_W-1:0] frame_w_r, frame_w_nxt;
  logic [CFG_DIM_W-1:0] frame_h_r, frame_h_nxt;
  logic [CFG_LEN_W-1:0] win_len_r, win_len_nxt;
  logic                 smooth_r, smooth_nxt;
  logic                 top_third_r, top_third_nxt;

  // union of this frame's person boxes
  logic [COORD_W-1:0] uleft_r, uleft_nxt;
  logic [COORD_W-1:0] utop_r, utop_nxt;
  logic [EXT_W-1:0]   uright_r, uright_nxt;
  logic [EXT_W-1:0]   ubottom_r, ubottom_nxt;
  logic               upresent_r, upresent_nxt;
  logic [EXT_W-1:0]   box_r, box_b;
  logic               box_take;

  // window
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUMC_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUMC_W-1:0] sum_y_r, sum_y_nxt;
  logic [SUME_W-1:0] sum_w_r, sum_w_nxt;
  logic [SUME_W-1:0] sum_h_r, sum_h_nxt;
  win_entry_t        cur, cur_r, cur_nxt, old;
  logic [LEN_W-1:0]  len_raw, len_eff, cnt_ext;
  logic              remove, append;
  logic [PTR_W-1:0]  ptr_inc, ptr1, waddr;
  logic [CNT_W-1:0]  cnt1;
  logic [PTR_W:0]    wsum;
  logic [$bits(win_entry_t)-1:0] ram_rdata;

  // region, divider and aspect fit
  logic [COORD_W-1:0]  rx_r, rx_nxt;
  logic [COORD_W-1:0]  ry_r, ry_nxt;
  logic [EXT_W-1:0]    rw_r, rw_nxt;
  logic [EXT_W-1:0]    rh_r, rh_nxt;
  logic [DIV_N_W-1:0]  prod_r, prod_nxt;
  logic [CROP_W_W-1:0] cw_r, cw_nxt;
  logic [CROP_X_W-1:0] cx_r, cx_nxt;
  logic [DIV_N_W-1:0]  div_num, q;
  logic [DIV_D_W-1:0]  div_den, fh_eff;
  logic                div_done;
  logic signed [CX_W-1:0] cw_s, rw_s, rx_s, fw_s, diff_s, half_s, cx0_s, cx1_s, cx2_s;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  out_word_t              ow;

  // ---------------------------------------------------------------- config
  always_comb begin
    frame_w_nxt   = frame_w_r;
    frame_h_nxt   = frame_h_r;
    win_len_nxt   = win_len_r;
    smooth_nxt    = smooth_r;
    top_third_nxt = top_third_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_W:   frame_w_nxt   = cfg_wdata[CFG_DIM_W-1:0];
        REG_FRAME_H:   frame_h_nxt   = cfg_wdata[CFG_DIM_W-1:0];
        REG_WIN_LEN:   win_len_nxt   = cfg_wdata[CFG_LEN_W-1:0];
        REG_SMOOTH:    smooth_nxt    = cfg_wdata[0];
        REG_TOP_THIRD: top_third_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- union
  always_comb begin
    box_r    = {2'b00, in_data.box_x} + {1'b0, in_data.box_w};
    box_b    = {2'b00, in_data.box_y} + {1'b0, in_data.box_h};
    box_take = in_fire && !in_mode && (in_data.class_id == PERSON_CLASS) &&
               (in_data.box_w != '0) && (in_data.box_h != '0);
    uleft_nxt    = uleft_r;
    utop_nxt     = utop_r;
    uright_nxt   = uright_r;
    ubottom_nxt  = ubottom_r;
    upresent_nxt = upresent_r;
    if (cmd.upd) begin
      uleft_nxt    = '0;
      utop_nxt     = '0;
      uright_nxt   = '0;
      ubottom_nxt  = '0;
      upresent_nxt = 1'b0;
    end else if (box_take) begin
      upresent_nxt = 1'b1;
      if (!upresent_r || in_data.box_x < uleft_r) uleft_nxt = in_data.box_x;
      if (!upresent_r || in_data.box_y < utop_r) utop_nxt = in_data.box_y;
      if (!upresent_r || box_r > uright_r) uright_nxt = box_r;
      if (!upresent_r || box_b > ubottom_r) ubottom_nxt = box_b;
    end
  end

  // ---------------------------------------------------------------- window
  always_comb begin
    cur.x = upresent_r ? uleft_r : '0;
    cur.y = upresent_r ? utop_r : '0;
    cur.w = upresent_r ? (uright_r - {2'b00, uleft_r}) : '0;
    cur.h = upresent_r ? (ubottom_r - {2'b00, utop_r}) : '0;
    old   = win_entry_t'(ram_rdata);

    len_raw = LEN_W'(win_len_r);
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_raw;
    end
    cnt_ext = LEN_W'(count_r);

    remove  = ((cnt_ext >= len_eff) || !upresent_r) && (count_r != '0);
    ptr_inc = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
    ptr1    = remove ? ptr_inc : ptr_r;
    cnt1    = count_r - CNT_W'(remove);
    append  = upresent_r && (cnt1 < CNT_FULL);
    wsum    = {1'b0, ptr1} + {1'b0, cnt1[PTR_W-1:0]};
    waddr   = (wsum >= PTR_WRAP) ? PTR_W'(wsum - PTR_WRAP) : wsum[PTR_W-1:0];

    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_w_nxt = sum_w_r;
    sum_h_nxt = sum_h_r;
    cur_nxt   = cur_r;
    if (cmd.upd) begin
      // drop the oldest entry if due and append this frame's union, if any, in one go
      ptr_nxt   = ptr1;
      count_nxt = cnt1 + CNT_W'(append);
      sum_x_nxt = sum_x_r - (remove ? SUMC_W'(old.x) : '0) + (append ? SUMC_W'(cur.x) : '0);
      sum_y_nxt = sum_y_r - (remove ? SUMC_W'(old.y) : '0) + (append ? SUMC_W'(cur.y) : '0);
      sum_w_nxt = sum_w_r - (remove ? SUME_W'(old.w) : '0) + (append ? SUME_W'(cur.w) : '0);
      sum_h_nxt = sum_h_r - (remove ? SUME_W'(old.h) : '0) + (append ? SUME_W'(cur.h) : '0);
      cur_nxt   = cur;
    end
  end

  spcw_ram #(
    .WIDTH ($bits(win_entry_t)),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.upd && append),
    .waddr (waddr),
    .wdata (cur),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- divide
  always_comb begin
    fh_eff = (frame_h_r == '0) ? DIV_D_W'(1) : frame_h_r;
    case (cmd.op)
      OP_AVG_X: begin
        div_num = DIV_N_W'(sum_x_r);
        div_den = DIV_D_W'(count_r);
      end
      OP_AVG_Y: begin
        div_num = DIV_N_W'(sum_y_r);
        div_den = DIV_D_W'(count_r);
      end
      OP_AVG_W: begin
        div_num = DIV_N_W'(sum_w_r);
        div_den = DIV_D_W'(count_r);
      end
      OP_AVG_H: begin
        div_num = DIV_N_W'(sum_h_r);
        div_den = DIV_D_W'(count_r);
      end
      OP_THIRD: begin
        div_num = DIV_N_W'(rw_r);
        div_den = THIRD_DIVISOR;
      end
      default: begin
        div_num = prod_r;
        div_den = fh_eff;
      end
    endcase
  end

  spcw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (q),
    .done  (div_done)
  );

  // ---------------------------------------------------------------- region
  always_comb begin
    cw_s   = $signed({{(CX_W - CROP_W_W){1'b0}}, cw_r});
    rw_s   = $signed({{(CX_W - EXT_W){1'b0}}, rw_r});
    rx_s   = $signed({{(CX_W - COORD_W){1'b0}}, rx_r});
    fw_s   = $signed({{(CX_W - CFG_DIM_W){1'b0}}, frame_w_r});
    diff_s = cw_s - rw_s;
    half_s = diff_s >>> 1;
    cx0_s  = rx_s - half_s;
    cx1_s  = (cx0_s < 0) ? '0 : cx0_s;
    cx2_s  = ((cx1_s + cw_s) > fw_s) ? (fw_s - cw_s) : cx1_s;

    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    rw_nxt   = rw_r;
    rh_nxt   = rh_r;
    prod_nxt = prod_r;
    cw_nxt   = cw_r;
    cx_nxt   = cx_r;
    if (cmd.load_cur) begin
      rx_nxt = cur_r.x;
      ry_nxt = cur_r.y;
      rw_nxt = cur_r.w;
      rh_nxt = cur_r.h;
    end
    if (cmd.div_wr) begin
      case (cmd.op)
        OP_AVG_X: rx_nxt = q[COORD_W-1:0];
        OP_AVG_Y: ry_nxt = q[COORD_W-1:0];
        OP_AVG_W: rw_nxt = q[EXT_W-1:0];
        OP_AVG_H: rh_nxt = q[EXT_W-1:0];
        OP_THIRD: begin
          // square the region and lift it by a third of its width
          rh_nxt = rw_r;
          ry_nxt = (EXT_W'(ry_r) >= q[EXT_W-1:0]) ? (ry_r - q[COORD_W-1:0]) : '0;
        end
        default: cw_nxt = (q > DIV_N_W'(CROP_W_MAX)) ? CROP_W_MAX : q[CROP_W_W-1:0];
      endcase
    end
    if (cmd.mul) begin
      prod_nxt = frame_w_r * rh_r;
    end
    if (cmd.fin) begin
      cx_nxt = cx2_s[CROP_X_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    ow.crop_x   = cx_r;
    ow.crop_y   = ry_r;
    ow.crop_w   = cw_r;
    ow.crop_h   = rh_r[OUT_EXT_W-1:0];
    ow.region_x = rx_r;
    ow.region_y = ry_r;
    ow.region_w = rw_r[OUT_EXT_W-1:0];
    ow.region_h = rh_r[OUT_EXT_W-1:0];

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = (count_r != '0);
      out_data_nxt  = (count_r != '0) ? OUT_TDATA_W'(ow) : '0;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r   <= FRAME_W_RST;
      frame_h_r   <= FRAME_H_RST;
      win_len_r   <= WIN_LEN_RST;
      smooth_r    <= SMOOTH_RST;
      top_third_r <= TOP_THIRD_RST;
      uleft_r     <= '0;
      utop_r      <= '0;
      uright_r    <= '0;
      ubottom_r   <= '0;
      upresent_r  <= 1'b0;
      ptr_r       <= '0;
      count_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_w_r     <= '0;
      sum_h_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      frame_w_r   <= frame_w_nxt;
      frame_h_r   <= frame_h_nxt;
      win_len_r   <= win_len_nxt;
      smooth_r    <= smooth_nxt;
      top_third_r <= top_third_nxt;
      uleft_r     <= uleft_nxt;
      utop_r      <= utop_nxt;
      uright_r    <= uright_nxt;
      ubottom_r   <= ubottom_nxt;
      upresent_r  <= upresent_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_w_r     <= sum_w_nxt;
      sum_h_r     <= sum_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rw_r       <= rw_nxt;
    rh_r       <= rh_nxt;
    prod_r     <= prod_nxt;
    cw_r       <= cw_nxt;
    cx_r       <= cx_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    stat.count_zero = (count_r == '0);
    stat.smooth     = smooth_r;
    stat.top_third  = top_third_r;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

@@ rtl/smoothed_person_crop_window_core.sv @@
`default_nettype none
// A box word gives no result; it is folded into the frame union in the cycle
// it is accepted. A frame-end word gives its result after the window update for
// an empty window, else after 1 to 6 passes of the shared radix-2 divider (four
// averages when smoothing, one for the top third, one for the aspect fit). Input
// is held off meanwhile.
// Reset (rst_n low at a clock edge) empties the window and the union and
// restores the default register values; the window RAM itself is not cleared.
// ----------------------------------------------------------------------------
// smoothed_person_crop_window_core
// Auto-framing crop: union of person boxes per frame, moving average over a
// window of frames, optional top-third reshape and aspect-ratio fit.
// ----------------------------------------------------------------------------
module smoothed_person_crop_window_core
  import spcw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // box_x[11:0], box_y[23:12], box_w[36:24], box_h[49:37], class_id[57:50]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[0]: 0 box word, 1 end of frame
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // crop_x[14:0], crop_y[26:15], crop_w[40:27], crop_h[53:41],
  // region_x[65:54], region_y[77:66], region_w[90:78], region_h[103:91]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // crop_valid[0]
  output logic                        out_tuser
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_tready = in_ready;

  spcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spcw_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_tvalid && in_ready),
    .in_mode    (in_tuser),
    .in_data    (in_word_t'(in_tdata)),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/spcw_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_checker
// Port-level checks for the crop window core, bound to the top level.
// ----------------------------------------------------------------------------
module spcw_checker
  import spcw_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   cfg_we,
  input wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // an empty window gives an all-zero word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("crop fields set with no region in window");

  // reset drops any pending result
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word survived reset");

  // a box word never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result word after a box word");

  // frame-end work holds off the next input word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken during frame-end work");

endmodule

bind smoothed_person_crop_window_core spcw_checker u_spcw_checker (.*);
`default_nettype wire
